@@ rtl/core/ispr_pkg.sv @@
package ispr_pkg;

   // sizes
   localparam int PAGE_BYTES   = 128;
   localparam int BUFFER_BYTES = 256;
   localparam int FLASH_BYTES  = 32768;
   localparam int EEPROM_BYTES = 1024;

   localparam int BUF_AW    = $clog2(BUFFER_BYTES);
   localparam int FLASH_AW  = $clog2(FLASH_BYTES);
   localparam int EEPROM_AW = $clog2(EEPROM_BYTES);
   localparam int LEN_W     = $clog2(BUFFER_BYTES + 1);
   localparam int LOOP_N    = (BUFFER_BYTES > PAGE_BYTES) ? BUFFER_BYTES : PAGE_BYTES;
   localparam int LOOP_W    = $clog2(LOOP_N + 1);
   localparam int CLEAR_N   = (FLASH_BYTES > EEPROM_BYTES) ? FLASH_BYTES : EEPROM_BYTES;
   localparam int CLEAR_W   = $clog2(CLEAR_N);
   localparam int CSR_AW    = 8;

   // protocol bytes
   localparam logic [7:0] SYNC_BYTE  = 8'h14;
   localparam logic [7:0] OK_BYTE    = 8'h10;
   localparam logic [7:0] MFR_SIG    = 8'h1E;
   localparam logic [7:0] TERM_BYTE  = 8'h20;
   localparam logic [7:0] V_SIG_BYTE = 8'h30;
   localparam logic [7:0] AT_LIMIT   = 8'h85;
   localparam logic [7:0] MEM_EEPROM = 8'h45;
   localparam logic [7:0] ERASED     = 8'hFF;

   // command codes
   localparam logic [7:0] CMD_HELLO  = 8'h30;
   localparam logic [7:0] CMD_ID     = 8'h31;
   localparam logic [7:0] CMD_PARM   = 8'h40;
   localparam logic [7:0] CMD_GETP   = 8'h41;
   localparam logic [7:0] CMD_DEVICE = 8'h42;
   localparam logic [7:0] CMD_DEVEXT = 8'h45;
   localparam logic [7:0] CMD_ENTER  = 8'h50;
   localparam logic [7:0] CMD_LEAVE  = 8'h51;
   localparam logic [7:0] CMD_ERASE  = 8'h52;
   localparam logic [7:0] CMD_ADDR   = 8'h55;
   localparam logic [7:0] CMD_UNIV   = 8'h56;
   localparam logic [7:0] CMD_WRITE  = 8'h64;
   localparam logic [7:0] CMD_READ   = 8'h74;
   localparam logic [7:0] CMD_SIG    = 8'h75;
   localparam logic [7:0] CMD_VER    = 8'h76;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_SIG_PART    = 8'd0;
   localparam logic [CSR_AW-1:0] CSR_SIG_VARIANT = 8'd1;
   localparam logic [CSR_AW-1:0] CSR_QUICK_START = 8'd2;
   localparam logic [CSR_AW-1:0] CSR_ERROR_LIMIT = 8'd3;

   // one byte towards the beat packer
   typedef struct packed {
      logic [7:0] data;
      logic       flush;
      logic       last;
      logic       launch;
   } pbyte_type;

   // id reply text
   function automatic logic [7:0] id_byte(input logic [2:0] i);
      logic [7:0] r;
      unique case (i)
         3'd0:    r = 8'h41;
         3'd1:    r = 8'h56;
         3'd2:    r = 8'h52;
         3'd3:    r = 8'h20;
         3'd4:    r = 8'h49;
         3'd5:    r = 8'h53;
         3'd6:    r = 8'h50;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/ispr_ram.sv @@
module ispr_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/core/ispr_packer.sv @@
module ispr_packer (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  ispr_pkg::pbyte_type byte_in,
   output logic              byte_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [63:0]       rsp_resp_bytes,
   output logic [3:0]        rsp_resp_count,
   output logic              rsp_resp_last,
   output logic              rsp_launch_app
);
   import ispr_pkg::*;

   logic [63:0] pack_ff, pack_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        valid_ff, valid_in;
   logic [63:0] bytes_ff, bytes_in;
   logic [3:0]  count_ff, count_in;
   logic        last_ff, last_in;
   logic        launch_ff, launch_in;
   logic [63:0] merged;
   logic [3:0]  cnt_next;
   logic        take;

   assign byte_ready = !valid_ff || !rsp_stall;
   assign take = byte_valid && byte_ready;

   // gather bytes, close a beat when full or flushed; a launch byte closes an empty launch beat
   always_comb begin
      merged = pack_ff;
      merged[{cnt_ff, 3'b000} +: 8] = byte_in.data;
      cnt_next = {1'b0, cnt_ff} + 4'd1;
      pack_in = pack_ff;
      cnt_in = cnt_ff;
      valid_in = valid_ff && rsp_stall;
      bytes_in = bytes_ff;
      count_in = count_ff;
      last_in = last_ff;
      launch_in = launch_ff;
      if (take) begin
         if (byte_in.launch) begin
            valid_in = 1'b1;
            bytes_in = '0;
            count_in = 4'd0;
            last_in = 1'b1;
            launch_in = 1'b1;
         end else if (byte_in.flush || cnt_next == 4'd8) begin
            valid_in = 1'b1;
            bytes_in = merged;
            count_in = cnt_next;
            last_in = byte_in.last;
            launch_in = 1'b0;
            pack_in = '0;
            cnt_in = 3'd0;
         end else begin
            pack_in = merged;
            cnt_in = cnt_next[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_ff <= '0;
         cnt_ff <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         pack_ff <= pack_in;
         cnt_ff <= cnt_in;
         valid_ff <= valid_in;
      end
      bytes_ff <= bytes_in;
      count_ff <= count_in;
      last_ff <= last_in;
      launch_ff <= launch_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_resp_bytes = bytes_ff;
   assign rsp_resp_count = count_ff;
   assign rsp_resp_last = last_ff;
   assign rsp_launch_app = launch_ff;

   // beat shape
   a_launch_empty: assert property (@(posedge clock) disable iff (reset)
      valid_ff && launch_ff |-> count_ff == 4'd0 && last_ff)
      else $error("launch beat carries bytes");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> count_ff <= 4'd8)
      else $error("beat count out of range");
   a_pack_empty_launch: assert property (@(posedge clock) disable iff (reset)
      take && byte_in.launch |-> cnt_ff == 3'd0)
      else $error("launch with bytes still packed");

endmodule

@@ rtl/core/isp_programming_command_responder.sv @@
// one received byte per beat; req_stall is high whenever the responder is not idle
// replies leave through a packer at one byte a cycle while the receiver does not
// stall, at most eight bytes a beat; read bursts and page or eeprom writes handle
// each byte in an address state and a data state (one registered read port per store)
// after reset the flash and eeprom stores are erased by a sweep over every flash
// address, req_stall high meanwhile; reset is synchronous, active high
module isp_programming_command_responder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [63:0]                 rsp_resp_bytes,
   output logic [3:0]                  rsp_resp_count,
   output logic                        rsp_resp_last,
   output logic                        rsp_launch_app,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ispr_pkg::CSR_AW-1:0] csr_index,
   input  logic [7:0]                  csr_data
);
   import ispr_pkg::*;

   typedef enum logic [9:0] {
      S_CLEAR   = 10'b0000000001,
      S_IDLE    = 10'b0000000010,
      S_SYNC    = 10'b0000000100,
      S_FIX     = 10'b0000001000,
      S_WR_RD   = 10'b0000010000,
      S_WR_WR   = 10'b0000100000,
      S_RD_ADDR = 10'b0001000000,
      S_RD_DATA = 10'b0010000000,
      S_END     = 10'b0100000000,
      S_LAUNCH  = 10'b1000000000
   } seq_state_type;

   typedef enum logic [13:0] {
      PH_CMD    = 14'b00000000000001,
      PH_TERM   = 14'b00000000000010,
      PH_SKIP   = 14'b00000000000100,
      PH_AT     = 14'b00000000001000,
      PH_A      = 14'b00000000010000,
      PH_ULO    = 14'b00000000100000,
      PH_UHI    = 14'b00000001000000,
      PH_VFIRST = 14'b00000010000000,
      PH_VPAD   = 14'b00000100000000,
      PH_VSEL   = 14'b00001000000000,
      PH_LHI    = 14'b00010000000000,
      PH_LLO    = 14'b00100000000000,
      PH_MEM    = 14'b01000000000000,
      PH_DATA   = 14'b10000000000000
   } phase_type;

   seq_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [4:0]  skip_ff, skip_in;
   logic [7:0]  sub_ff, sub_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic        eesel_ff, eesel_in;
   logic        started_ff, started_in;
   logic [7:0]  tally_ff, tally_in;
   logic [15:0] page_ff, page_in;
   logic        halted_ff, halted_in;
   logic        lpend_ff, lpend_in;
   logic [LOOP_W-1:0] loop_ff, loop_in;
   logic [2:0]  fix_ff, fix_in;
   logic        zero_ff, zero_in;
   logic [CLEAR_W-1:0] clr_ff, clr_in;
   logic [7:0]  sig_part_ff, sig_variant_ff, err_limit_ff;
   logic        quick_ff;

   logic        accept, hit, launch_now;
   logic [7:0]  b, tally_inc;
   logic [15:0] len_full;
   logic [2:0]  fix_last;
   logic [LOOP_W-1:0] loop_inc;
   logic [15:0] page_sum;

   logic        pb_valid, pb_ready;
   pbyte_type   pb;

   logic        buf_we, buf_re;
   logic [BUF_AW-1:0] buf_wa, buf_ra;
   logic [7:0]  buf_rd;
   logic        fl_we, fl_re, ee_we, ee_re;
   logic [FLASH_AW-1:0]  fl_wa;
   logic [EEPROM_AW-1:0] ee_wa;
   logic [7:0]  fl_wd, ee_wd, fl_rd, ee_rd, wr_byte;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign b = req_rx_byte;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sig_part_ff <= 8'd149;
         sig_variant_ff <= 8'd15;
         quick_ff <= 1'b1;
         err_limit_ff <= 8'd5;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SIG_PART:    sig_part_ff <= csr_data;
            CSR_SIG_VARIANT: sig_variant_ff <= csr_data;
            CSR_QUICK_START: quick_ff <= csr_data[0];
            CSR_ERROR_LIMIT: err_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign tally_inc = tally_ff + 8'd1;
   assign hit = (tally_inc == err_limit_ff);
   assign len_full = {len_hi_ff, b};
   assign loop_inc = loop_ff + LOOP_W'(1);
   assign page_sum = page_ff + 16'(loop_ff);
   assign fix_last = (cmd_ff == CMD_ID) ? 3'd6 : (cmd_ff == CMD_SIG) ? 3'd2 : 3'd0;
   assign wr_byte = zero_ff ? 8'h00 : buf_rd;

   // parser and reply sequencer
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd_in = cmd_ff;
      skip_in = skip_ff;
      sub_in = sub_ff;
      addr_in = addr_ff;
      len_hi_in = len_hi_ff;
      len_in = len_ff;
      idx_in = idx_ff;
      eesel_in = eesel_ff;
      started_in = started_ff;
      tally_in = tally_ff;
      page_in = page_ff;
      halted_in = halted_ff;
      lpend_in = lpend_ff;
      loop_in = loop_ff;
      fix_in = fix_ff;
      zero_in = zero_ff;
      clr_in = clr_ff;
      launch_now = 1'b0;
      pb_valid = 1'b0;
      pb = '{data: 8'h00, flush: 1'b0, last: 1'b0, launch: 1'b0};
      buf_we = 1'b0;
      buf_wa = idx_ff[BUF_AW-1:0];
      buf_re = 1'b0;
      buf_ra = loop_ff[BUF_AW-1:0];
      fl_we = 1'b0;
      fl_wa = page_sum[FLASH_AW-1:0];
      fl_wd = wr_byte;
      ee_we = 1'b0;
      ee_wa = addr_ff[EEPROM_AW-1:0];
      ee_wd = wr_byte;
      fl_re = 1'b0;
      ee_re = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            fl_wa = clr_ff[FLASH_AW-1:0];
            fl_wd = ERASED;
            ee_wa = clr_ff[EEPROM_AW-1:0];
            ee_wd = ERASED;
            fl_we = ((CLEAR_W + 1)'(clr_ff) < (CLEAR_W + 1)'(FLASH_BYTES));
            ee_we = ((CLEAR_W + 1)'(clr_ff) < (CLEAR_W + 1)'(EEPROM_BYTES));
            clr_in = clr_ff + CLEAR_W'(1);
            if (clr_ff == CLEAR_W'(CLEAR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && !halted_ff) begin
               unique case (phase_ff)
                  PH_CMD: begin
                     cmd_in = b;
                     sub_in = 8'h00;
                     if (b == CMD_HELLO) begin
                        started_in = 1'b1;
                        phase_in = PH_TERM;
                     end else if (!started_ff) begin
                        launch_now = 1'b1;
                     end else begin
                        unique case (b) inside
                           CMD_ID, CMD_ENTER, CMD_ERASE, CMD_LEAVE, CMD_SIG, CMD_VER:
                              phase_in = PH_TERM;
                           CMD_PARM: phase_in = PH_AT;
                           CMD_GETP: phase_in = PH_A;
                           CMD_DEVICE: begin
                              skip_in = 5'd20;
                              phase_in = PH_SKIP;
                           end
                           CMD_DEVEXT: begin
                              skip_in = 5'd5;
                              phase_in = PH_SKIP;
                           end
                           CMD_ADDR: phase_in = PH_ULO;
                           CMD_UNIV: phase_in = PH_VFIRST;
                           CMD_WRITE, CMD_READ: phase_in = PH_LHI;
                           default: begin
                              tally_in = tally_inc;
                              launch_now = hit;
                           end
                        endcase
                     end
                  end
                  PH_TERM: begin
                     phase_in = PH_CMD;
                     if (b != TERM_BYTE) begin
                        if (cmd_ff != CMD_READ) begin
                           tally_in = tally_inc;
                        end
                        launch_now = ((cmd_ff != CMD_READ) && hit)
                                     || ((cmd_ff == CMD_LEAVE) && quick_ff);
                     end else begin
                        lpend_in = (cmd_ff == CMD_LEAVE) && quick_ff;
                        halted_in = (cmd_ff == CMD_LEAVE) && quick_ff;
                        state_in = S_SYNC;
                     end
                  end
                  PH_SKIP: begin
                     if (skip_ff > 5'd1) begin
                        skip_in = skip_ff - 5'd1;
                     end else begin
                        skip_in = 5'd0;
                        phase_in = PH_TERM;
                     end
                  end
                  PH_AT: begin
                     if (b > AT_LIMIT) begin
                        skip_in = 5'd1;
                        phase_in = PH_SKIP;
                     end else begin
                        phase_in = PH_TERM;
                     end
                  end
                  PH_A: begin
                     case (b)
                        8'h80:   sub_in = 8'h02;
                        8'h81:   sub_in = 8'h01;
                        8'h82:   sub_in = 8'h10;
                        8'h98:   sub_in = 8'h03;
                        default: sub_in = 8'h00;
                     endcase
                     phase_in = PH_TERM;
                  end
                  PH_ULO: begin
                     addr_in = {addr_ff[15:8], b};
                     phase_in = PH_UHI;
                  end
                  PH_UHI: begin
                     addr_in = {b[6:0], addr_ff[7:0], 1'b0};
                     phase_in = PH_TERM;
                  end
                  PH_VFIRST: begin
                     if (b == V_SIG_BYTE) begin
                        phase_in = PH_VPAD;
                     end else begin
                        skip_in = 5'd3;
                        phase_in = PH_SKIP;
                     end
                  end
                  PH_VPAD: phase_in = PH_VSEL;
                  PH_VSEL: begin
                     sub_in = (b == 8'd0) ? MFR_SIG :
                              (b == 8'd1) ? sig_part_ff : sig_variant_ff;
                     skip_in = 5'd1;
                     phase_in = PH_SKIP;
                  end
                  PH_LHI: begin
                     len_hi_in = b;
                     phase_in = PH_LLO;
                  end
                  PH_LLO: begin
                     len_in = (len_full > 16'(BUFFER_BYTES)) ? LEN_W'(BUFFER_BYTES)
                                                             : len_full[LEN_W-1:0];
                     phase_in = PH_MEM;
                  end
                  PH_MEM: begin
                     eesel_in = (b == MEM_EEPROM);
                     idx_in = '0;
                     phase_in = ((cmd_ff == CMD_WRITE) && (len_ff != '0)) ? PH_DATA
                                                                          : PH_TERM;
                  end
                  PH_DATA: begin
                     buf_we = 1'b1;
                     idx_in = idx_ff + LEN_W'(1);
                     if (idx_in >= len_ff) begin
                        phase_in = PH_TERM;
                     end
                  end
                  default: phase_in = PH_CMD;
               endcase
               if (launch_now) begin
                  halted_in = 1'b1;
                  state_in = S_LAUNCH;
               end
            end
         end
         S_SYNC: begin
            pb_valid = 1'b1;
            pb.data = SYNC_BYTE;
            if (pb_ready) begin
               loop_in = '0;
               fix_in = 3'd0;
               unique case (cmd_ff) inside
                  CMD_ID, CMD_SIG, CMD_GETP, CMD_UNIV, CMD_VER: state_in = S_FIX;
                  CMD_WRITE:
                     state_in = (eesel_ff && (len_ff == '0)) ? S_END : S_WR_RD;
                  CMD_READ:
                     state_in = (len_ff == '0) ? S_END : S_RD_ADDR;
                  default: state_in = S_END;
               endcase
            end
         end
         S_FIX: begin
            pb_valid = 1'b1;
            if (cmd_ff == CMD_ID) begin
               pb.data = id_byte(fix_ff);
            end else if (cmd_ff == CMD_SIG) begin
               pb.data = (fix_ff == 3'd0) ? MFR_SIG :
                         (fix_ff == 3'd1) ? sig_part_ff : sig_variant_ff;
            end else begin
               pb.data = sub_ff;
            end
            if (pb_ready) begin
               fix_in = fix_ff + 3'd1;
               if (fix_ff == fix_last) begin
                  state_in = S_END;
               end
            end
         end
         S_WR_RD: begin
            buf_re = 1'b1;
            zero_in = (loop_ff >= LOOP_W'(BUFFER_BYTES));
            state_in = S_WR_WR;
         end
         S_WR_WR: begin
            loop_in = loop_inc;
            state_in = S_WR_RD;
            if (eesel_ff) begin
               ee_we = 1'b1;
               addr_in = addr_ff + 16'd1;
               if (loop_inc == LOOP_W'(len_ff)) begin
                  state_in = S_END;
               end
            end else begin
               fl_we = 1'b1;
               if (loop_inc == LOOP_W'(PAGE_BYTES)) begin
                  page_in = page_ff + 16'(PAGE_BYTES);
                  state_in = S_END;
               end
            end
         end
         S_RD_ADDR: begin
            fl_re = 1'b1;
            ee_re = 1'b1;
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            pb_valid = 1'b1;
            pb.data = eesel_ff ? ee_rd : fl_rd;
            if (pb_ready) begin
               addr_in = addr_ff + 16'd1;
               loop_in = loop_inc;
               state_in = (loop_inc == LOOP_W'(len_ff)) ? S_END : S_RD_ADDR;
            end
         end
         S_END: begin
            pb_valid = 1'b1;
            pb.data = OK_BYTE;
            pb.flush = 1'b1;
            pb.last = !lpend_ff;
            if (pb_ready) begin
               state_in = lpend_ff ? S_LAUNCH : S_IDLE;
               lpend_in = 1'b0;
            end
         end
         S_LAUNCH: begin
            pb_valid = 1'b1;
            pb.launch = 1'b1;
            pb.last = 1'b1;
            if (pb_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         phase_ff <= PH_CMD;
         cmd_ff <= 8'h00;
         skip_ff <= 5'd0;
         sub_ff <= 8'h00;
         addr_ff <= 16'd0;
         len_hi_ff <= 8'h00;
         len_ff <= '0;
         idx_ff <= '0;
         eesel_ff <= 1'b0;
         started_ff <= 1'b0;
         tally_ff <= 8'h00;
         page_ff <= 16'd0;
         halted_ff <= 1'b0;
         lpend_ff <= 1'b0;
         loop_ff <= '0;
         fix_ff <= 3'd0;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cmd_ff <= cmd_in;
         skip_ff <= skip_in;
         sub_ff <= sub_in;
         addr_ff <= addr_in;
         len_hi_ff <= len_hi_in;
         len_ff <= len_in;
         idx_ff <= idx_in;
         eesel_ff <= eesel_in;
         started_ff <= started_in;
         tally_ff <= tally_in;
         page_ff <= page_in;
         halted_ff <= halted_in;
         lpend_ff <= lpend_in;
         loop_ff <= loop_in;
         fix_ff <= fix_in;
         clr_ff <= clr_in;
      end
      zero_ff <= zero_in;
   end

   // stores
   ispr_ram #(.DEPTH(BUFFER_BYTES), .WIDTH(8)) u_page_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_wa),
      .wr_data (b),
      .rd_en   (buf_re),
      .rd_addr (buf_ra),
      .rd_data (buf_rd)
   );

   ispr_ram #(.DEPTH(FLASH_BYTES), .WIDTH(8)) u_flash (
      .clock   (clock),
      .wr_en   (fl_we),
      .wr_addr (fl_wa),
      .wr_data (fl_wd),
      .rd_en   (fl_re),
      .rd_addr (addr_ff[FLASH_AW-1:0]),
      .rd_data (fl_rd)
   );

   ispr_ram #(.DEPTH(EEPROM_BYTES), .WIDTH(8)) u_eeprom (
      .clock   (clock),
      .wr_en   (ee_we),
      .wr_addr (ee_wa),
      .wr_data (ee_wd),
      .rd_en   (ee_re),
      .rd_addr (addr_ff[EEPROM_AW-1:0]),
      .rd_data (ee_rd)
   );

   // reply beats
   ispr_packer u_packer (
      .clock          (clock),
      .reset          (reset),
      .byte_valid     (pb_valid),
      .byte_in        (pb),
      .byte_ready     (pb_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_resp_bytes (rsp_resp_bytes),
      .rsp_resp_count (rsp_resp_count),
      .rsp_resp_last  (rsp_resp_last),
      .rsp_launch_app (rsp_launch_app)
   );

   // sequencing checks
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("hand-over flag dropped");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid && !pb_valid)
      else $error("reply during erase sweep");
   a_launch_halted: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LAUNCH |-> halted_ff)
      else $error("launch without hand-over flag");
   a_one_store_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WR_WR |-> !(fl_we && ee_we))
      else $error("both stores written by one byte");

endmodule

@@ verif/isp_responder_checker.sv @@
module isp_responder_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [63:0]                 rsp_resp_bytes,
   input  logic [3:0]                  rsp_resp_count,
   input  logic                        rsp_resp_last,
   input  logic                        rsp_launch_app,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [ispr_pkg::CSR_AW-1:0] csr_index,
   input  logic [7:0]                  csr_data,
   output int                          fail_count,
   output int                          replies_waiting,
   output int                          beats_checked,
   output bit                          launched
);

   timeunit 1ns;
   timeprecision 1ps;

   import ispr_pkg::*;

   typedef enum logic [3:0] {
      PH_CMD, PH_TERM, PH_SKIP, PH_AT, PH_A, PH_ULO, PH_UHI, PH_VFIRST,
      PH_VPAD, PH_VSEL, PH_LHI, PH_LLO, PH_MEM, PH_DATA
   } parse_phase_type;

   typedef struct {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
      logic        launch;
   } reply_beat_type;

   // configuration copy
   logic [7:0] sig_part, sig_variant, err_limit;
   logic       quick_start;

   // parser state
   parse_phase_type phase;
   logic [7:0]   cmd, skip_cnt, sub_byte, err_tally;
   logic [15:0]  mem_addr, xfer_len, byte_idx, page_addr;
   logic         eep_sel, started, halted;

   logic [7:0] page_buf [BUFFER_BYTES];
   logic [7:0] flash_mem [FLASH_BYTES];
   logic [7:0] eeprom_mem [EEPROM_BYTES];

   logic [7:0]  reply_bytes [$];
   bit          launch_now;
   reply_beat_type reply_q [$];

   assign launched = halted;

   task automatic do_launch();
      launch_now = 1;
      halted = 1;
   endtask

   task automatic count_error();
      err_tally = err_tally + 8'd1;
      if (err_tally == err_limit) do_launch();
   endtask

   // terminator byte: reply or error
   task automatic close_command(input logic [7:0] b);
      phase = PH_CMD;
      if (b != TERM_BYTE) begin
         if (cmd != CMD_READ) count_error();
         if (cmd == CMD_LEAVE && quick_start && !launch_now) do_launch();
         return;
      end
      reply_bytes.push_back(SYNC_BYTE);
      case (cmd)
         CMD_ID: begin
            reply_bytes.push_back(8'h41); reply_bytes.push_back(8'h56);
            reply_bytes.push_back(8'h52); reply_bytes.push_back(8'h20);
            reply_bytes.push_back(8'h49); reply_bytes.push_back(8'h53);
            reply_bytes.push_back(8'h50);
         end
         CMD_SIG: begin
            reply_bytes.push_back(MFR_SIG);
            reply_bytes.push_back(sig_part);
            reply_bytes.push_back(sig_variant);
         end
         CMD_GETP, CMD_UNIV, CMD_VER: reply_bytes.push_back(sub_byte);
         CMD_WRITE: begin
            if (eep_sel) begin
               for (int w = 0; w < xfer_len && w < BUFFER_BYTES; w++) begin
                  eeprom_mem[mem_addr[EEPROM_AW-1:0]] = page_buf[w];
                  mem_addr = mem_addr + 16'd1;
               end
            end else begin
               for (int w = 0; w < PAGE_BYTES; w++)
                  flash_mem[(int'(page_addr) + w) % FLASH_BYTES] =
                     (w < BUFFER_BYTES) ? page_buf[w] : 8'h00;
               page_addr = page_addr + 16'(PAGE_BYTES);
            end
         end
         CMD_READ: begin
            for (int w = 0; w < xfer_len; w++) begin
               reply_bytes.push_back(eep_sel ? eeprom_mem[mem_addr[EEPROM_AW-1:0]]
                                             : flash_mem[mem_addr[FLASH_AW-1:0]]);
               mem_addr = mem_addr + 16'd1;
            end
         end
         default: ;
      endcase
      reply_bytes.push_back(OK_BYTE);
      if (cmd == CMD_LEAVE && quick_start) do_launch();
   endtask

   task automatic take_command(input logic [7:0] b);
      cmd = b;
      sub_byte = 8'h00;
      if (b == CMD_HELLO) begin
         started = 1;
         phase = PH_TERM;
         return;
      end
      if (!started) begin
         do_launch();
         return;
      end
      case (b)
         CMD_ID, CMD_ENTER, CMD_ERASE, CMD_LEAVE, CMD_SIG, CMD_VER: phase = PH_TERM;
         CMD_PARM:   phase = PH_AT;
         CMD_GETP:   phase = PH_A;
         CMD_DEVICE: begin skip_cnt = 8'd20; phase = PH_SKIP; end
         CMD_DEVEXT: begin skip_cnt = 8'd5; phase = PH_SKIP; end
         CMD_ADDR:   phase = PH_ULO;
         CMD_UNIV:   phase = PH_VFIRST;
         CMD_WRITE, CMD_READ: phase = PH_LHI;
         default:    count_error();
      endcase
   endtask

   task automatic take_byte(input logic [7:0] b);
      case (phase)
         PH_TERM: close_command(b);
         PH_SKIP: begin
            if (skip_cnt > 1) skip_cnt--;
            else begin skip_cnt = 0; phase = PH_TERM; end
         end
         PH_AT: begin
            if (b > AT_LIMIT) begin skip_cnt = 8'd1; phase = PH_SKIP; end
            else phase = PH_TERM;
         end
         PH_A: begin
            case (b)
               8'h80:   sub_byte = 8'h02;
               8'h81:   sub_byte = 8'h01;
               8'h82:   sub_byte = 8'h10;
               8'h98:   sub_byte = 8'h03;
               default: sub_byte = 8'h00;
            endcase
            phase = PH_TERM;
         end
         PH_ULO: begin mem_addr[7:0] = b; phase = PH_UHI; end
         PH_UHI: begin
            mem_addr[15:8] = b;
            mem_addr = mem_addr << 1;
            phase = PH_TERM;
         end
         PH_VFIRST: begin
            if (b == V_SIG_BYTE) phase = PH_VPAD;
            else begin skip_cnt = 8'd3; phase = PH_SKIP; end
         end
         PH_VPAD: phase = PH_VSEL;
         PH_VSEL: begin
            sub_byte = (b == 8'd0) ? MFR_SIG : (b == 8'd1) ? sig_part : sig_variant;
            skip_cnt = 8'd1;
            phase = PH_SKIP;
         end
         PH_LHI: begin xfer_len = {b, 8'h00}; phase = PH_LLO; end
         PH_LLO: begin
            xfer_len[7:0] = b;
            if (xfer_len > BUFFER_BYTES) xfer_len = 16'(BUFFER_BYTES);
            phase = PH_MEM;
         end
         PH_MEM: begin
            eep_sel = (b == MEM_EEPROM);
            byte_idx = 16'd0;
            phase = (cmd == CMD_WRITE && xfer_len > 0) ? PH_DATA : PH_TERM;
         end
         PH_DATA: begin
            if (byte_idx < BUFFER_BYTES) page_buf[byte_idx] = b;
            byte_idx = byte_idx + 16'd1;
            if (byte_idx >= xfer_len) phase = PH_TERM;
         end
         default: take_command(b);
      endcase
   endtask

   // work out the reply beats for one received byte
   task automatic predict_reply(input logic [7:0] b);
      reply_beat_type beat;
      int pos, k, first;
      if (halted) return;
      reply_bytes.delete();
      launch_now = 0;
      first = reply_q.size();
      take_byte(b);
      pos = 0;
      while (pos < reply_bytes.size()) begin
         beat = '{64'd0, 4'd0, 1'b0, 1'b0};
         k = 0;
         while (k < 8 && pos < reply_bytes.size()) begin
            beat.data[8*k +: 8] = reply_bytes[pos];
            k++;
            pos++;
         end
         beat.count = 4'(k);
         reply_q.push_back(beat);
      end
      if (launch_now) reply_q.push_back('{64'd0, 4'd0, 1'b0, 1'b1});
      if (reply_q.size() > first) reply_q[reply_q.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      reply_beat_type want;
      if (reset) begin
         sig_part = 8'd149; sig_variant = 8'd15; quick_start = 1'b1; err_limit = 8'd5;
         phase = PH_CMD;
         cmd = 0; skip_cnt = 0; sub_byte = 0; err_tally = 0;
         mem_addr = 0; xfer_len = 0; byte_idx = 0; page_addr = 0;
         eep_sel = 0; started = 0; halted = 0;
         foreach (flash_mem[i]) flash_mem[i] = ERASED;
         foreach (eeprom_mem[i]) eeprom_mem[i] = ERASED;
         reply_q.delete();
         fail_count = 0;
         beats_checked = 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIG_PART:    sig_part = csr_data;
               CSR_SIG_VARIANT: sig_variant = csr_data;
               CSR_QUICK_START: quick_start = csr_data[0];
               CSR_ERROR_LIMIT: err_limit = csr_data;
               default: ;
            endcase
         end
         // result beat against oldest expectation
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            if (reply_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected beat bytes=%h count=%0d last=%0b launch=%0b",
                        $realtime, rsp_resp_bytes, rsp_resp_count, rsp_resp_last,
                        rsp_launch_app);
            end else begin
               want = reply_q.pop_front();
               if (rsp_resp_bytes !== want.data) begin
                  fail_count++;
                  $display("%0t: resp_bytes expected %h actual %h",
                           $realtime, want.data, rsp_resp_bytes);
               end
               if (rsp_resp_count !== want.count) begin
                  fail_count++;
                  $display("%0t: resp_count expected %0d actual %0d",
                           $realtime, want.count, rsp_resp_count);
               end
               if (rsp_resp_last !== want.last) begin
                  fail_count++;
                  $display("%0t: resp_last expected %0b actual %0b",
                           $realtime, want.last, rsp_resp_last);
               end
               if (rsp_launch_app !== want.launch) begin
                  fail_count++;
                  $display("%0t: launch_app expected %0b actual %0b",
                           $realtime, want.launch, rsp_launch_app);
               end
            end
         end
         // received byte
         if (req_valid && !req_stall) predict_reply(req_rx_byte);
      end
      replies_waiting = reply_q.size();
   end

endmodule

@@ verif/tb_isp_programming_command_responder.sv @@
module tb_isp_programming_command_responder;

   timeunit 1ns;
   timeprecision 1ps;

   import ispr_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_rx_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [63:0]         rsp_resp_bytes;
   logic [3:0]          rsp_resp_count;
   logic                rsp_resp_last;
   logic                rsp_launch_app;
   logic                csr_valid;
   logic                csr_ready;
   logic [CSR_AW-1:0]   csr_index;
   logic [7:0]          csr_data;

   int fail_count, replies_waiting, beats_checked;
   bit launched;
   int send_idle_pct, recv_idle_pct;
   int commands_sent;

   isp_programming_command_responder dut (.*);
   isp_responder_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // run limit
   initial begin
      #30ms;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
   endtask

   // let every reply drain, then allow for trailing store writes
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (replies_waiting != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_term();
      return ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : TERM_BYTE;
   endfunction

   function automatic bit is_command(input logic [7:0] b);
      case (b)
         CMD_HELLO, CMD_ID, CMD_PARM, CMD_GETP, CMD_DEVICE, CMD_DEVEXT, CMD_ENTER,
         CMD_LEAVE, CMD_ERASE, CMD_ADDR, CMD_UNIV, CMD_WRITE, CMD_READ, CMD_SIG,
         CMD_VER: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   task automatic plain_cmd(input logic [7:0] c, input logic [7:0] term);
      send_byte(c);
      send_byte(term);
   endtask

   task automatic transfer_cmd(input logic [7:0] c, input logic [15:0] len,
                               input logic [7:0] mem, input logic [7:0] term);
      int n;
      send_byte(c);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      send_byte(mem);
      n = (len > BUFFER_BYTES) ? BUFFER_BYTES : len;
      if (c == CMD_WRITE)
         repeat (n) send_byte(8'($urandom_range(255)));
      send_byte(term);
   endtask

   task automatic univ_cmd(input logic [7:0] first, input logic [7:0] s,
                           input logic [7:0] term);
      send_byte(CMD_UNIV);
      send_byte(first);
      send_byte(8'($urandom_range(255)));
      send_byte(s);
      send_byte(8'($urandom_range(255)));
      send_byte(term);
   endtask

   // one command with random content, at times with a wrong terminator, or an unknown byte
   task automatic random_command();
      logic [7:0] b;
      logic [15:0] len;
      int kind;
      kind = $urandom_range(15);
      commands_sent++;
      case (kind)
         0: begin
            do b = 8'($urandom_range(255)); while (is_command(b));
            send_byte(b);
         end
         1: plain_cmd(CMD_ID, pick_term());
         2: plain_cmd(CMD_SIG, pick_term());
         3: plain_cmd(CMD_VER, pick_term());
         4: begin
            case ($urandom_range(2))
               0: b = CMD_ENTER;
               1: b = CMD_ERASE;
               default: b = CMD_HELLO;
            endcase
            plain_cmd(b, pick_term());
         end
         5: begin
            b = 8'($urandom_range(255));
            send_byte(CMD_PARM);
            send_byte(b);
            if (b > AT_LIMIT) send_byte(8'($urandom_range(255)));
            send_byte(pick_term());
         end
         6: begin
            send_byte(CMD_GETP);
            case ($urandom_range(4))
               0: send_byte(8'h80);
               1: send_byte(8'h81);
               2: send_byte(8'h82);
               3: send_byte(8'h98);
               default: send_byte(8'($urandom_range(255)));
            endcase
            send_byte(pick_term());
         end
         7: begin
            send_byte(($urandom_range(1) == 0) ? CMD_DEVICE : CMD_DEVEXT);
            repeat ((req_rx_byte == CMD_DEVICE) ? 20 : 5)
               send_byte(8'($urandom_range(255)));
            send_byte(pick_term());
         end
         8, 9: begin
            send_byte(CMD_ADDR);
            send_byte(8'($urandom_range(255)));
            send_byte(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255)));
            send_byte(pick_term());
         end
         10: univ_cmd(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : V_SIG_BYTE,
                      8'($urandom_range(3)), pick_term());
         11, 12: begin
            len = 16'($urandom_range(16));
            transfer_cmd(CMD_WRITE, len,
                         ($urandom_range(1) == 0) ? MEM_EEPROM : 8'h46, pick_term());
         end
         default: begin
            len = ($urandom_range(24) == 0) ? 16'($urandom_range(65535))
                                           : 16'($urandom_range(20));
            transfer_cmd(CMD_READ, len,
                         ($urandom_range(1) == 0) ? MEM_EEPROM : 8'($urandom_range(255)),
                         pick_term());
         end
      endcase
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct, input int n);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (n) random_command();
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = 8'h00;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      commands_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extreme signature bytes, no quick start, highest error limit
      write_reg(CSR_SIG_PART, 8'h00);
      write_reg(CSR_SIG_VARIANT, 8'hFF);
      write_reg(CSR_QUICK_START, 8'h00);
      write_reg(CSR_ERROR_LIMIT, 8'hFF);

      // directed: every command but leave, argument extremes, error paths
      plain_cmd(CMD_HELLO, TERM_BYTE);
      plain_cmd(CMD_ID, TERM_BYTE);
      plain_cmd(CMD_SIG, TERM_BYTE);
      plain_cmd(CMD_VER, TERM_BYTE);
      plain_cmd(CMD_ENTER, TERM_BYTE);
      plain_cmd(CMD_ERASE, 8'hFF);
      send_byte(CMD_PARM); send_byte(8'h86); send_byte(8'h00); send_byte(TERM_BYTE);
      send_byte(CMD_PARM); send_byte(8'h85); send_byte(TERM_BYTE);
      send_byte(CMD_GETP); send_byte(8'h98); send_byte(TERM_BYTE);
      send_byte(CMD_GETP); send_byte(8'h81); send_byte(TERM_BYTE);
      send_byte(CMD_DEVICE); repeat (20) send_byte(8'hFF); send_byte(TERM_BYTE);
      send_byte(CMD_DEVEXT); repeat (5) send_byte(8'h00); send_byte(TERM_BYTE);
      univ_cmd(V_SIG_BYTE, 8'd0, TERM_BYTE);
      univ_cmd(V_SIG_BYTE, 8'd1, TERM_BYTE);
      univ_cmd(V_SIG_BYTE, 8'd2, TERM_BYTE);
      univ_cmd(8'h00, 8'd0, TERM_BYTE);
      // fill a flash page from the start of the buffer, then read it back
      transfer_cmd(CMD_WRITE, 16'(PAGE_BYTES), 8'h46, TERM_BYTE);
      send_byte(CMD_ADDR); send_byte(8'h00); send_byte(8'h00); send_byte(TERM_BYTE);
      transfer_cmd(CMD_READ, 16'hFFFF, 8'h46, TERM_BYTE);
      // eeprom near the top of the address space wraps
      send_byte(CMD_ADDR); send_byte(8'hFF); send_byte(8'hFF); send_byte(TERM_BYTE);
      transfer_cmd(CMD_WRITE, 16'd3, MEM_EEPROM, TERM_BYTE);
      send_byte(CMD_ADDR); send_byte(8'hFF); send_byte(8'hFF); send_byte(TERM_BYTE);
      transfer_cmd(CMD_READ, 16'd4, MEM_EEPROM, TERM_BYTE);
      transfer_cmd(CMD_WRITE, 16'd2, MEM_EEPROM, TERM_BYTE);
      transfer_cmd(CMD_READ, 16'd2, MEM_EEPROM, 8'h00);
      transfer_cmd(CMD_WRITE, 16'd0, 8'h46, TERM_BYTE);
      send_byte(8'hFF);
      send_byte(8'h00);
      plain_cmd(CMD_ID, 8'h21);
      drain();

      // random traffic under three idling patterns
      random_phase(25, 69, 5);
      write_reg(CSR_SIG_PART, 8'hFF);
      write_reg(CSR_SIG_VARIANT, 8'h00);
      write_reg(CSR_ERROR_LIMIT, 8'h01);
      random_phase(69, 25, 5);
      write_reg(CSR_SIG_PART, 8'($urandom_range(255)));
      write_reg(CSR_SIG_VARIANT, 8'($urandom_range(255)));
      write_reg(CSR_ERROR_LIMIT, 8'hFF);
      random_phase(0, 0, 5);

      // leave programming with quick start hands over; later bytes are ignored
      write_reg(CSR_QUICK_START, 8'h01);
      send_idle_pct = 10;
      recv_idle_pct = 30;
      plain_cmd(CMD_LEAVE, TERM_BYTE);
      send_byte(CMD_ID);
      send_byte(TERM_BYTE);
      drain();

      $display("run covered %0d random commands plus directed ones, %0d reply beats checked",
               commands_sent, beats_checked);
      $display("launch seen: %0b, three idling patterns and several register settings",
               launched);
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
